// ===== rtl/cccv_pkg.sv =====
// shared constants, codes and saturation helper for the cc/cv charge controller
`timescale 1ns / 1ps

package cccv_pkg;

  // number format
  localparam int unsigned DataW    = 16;
  localparam int unsigned FracBits = 14;
  localparam int unsigned RegW     = DataW - 1;
  localparam int unsigned ErrW     = DataW + 2;          // reference minus feedback
  localparam int unsigned MagW     = ErrW - 1;           // magnitude of the error
  localparam int unsigned ProdW    = MagW + RegW;        // magnitude times gain
  localparam int unsigned RndW     = ProdW - FracBits + 1; // rounded, signed
  localparam int unsigned SumW     = RndW + 1;           // integrator plus term
  localparam int unsigned One      = 1 << FracBits;

  // stream payload widths, padded to whole bytes
  localparam int unsigned InW  = ((2 * DataW + 2 + 7) / 8) * 8;
  localparam int unsigned OutW = ((DataW + 3 + 7) / 8) * 8;

  // charge modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_CC   = 2'd1;
  localparam logic [1:0] MODE_CV   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_CURRENT_SETPOINT = 3'd0;
  localparam logic [2:0] REG_VOLTAGE_SETPOINT = 3'd1;
  localparam logic [2:0] REG_CUTOFF_CURRENT   = 3'd2;
  localparam logic [2:0] REG_HYSTERESIS_BAND  = 3'd3;
  localparam logic [2:0] REG_CURRENT_KP       = 3'd4;
  localparam logic [2:0] REG_CURRENT_KI       = 3'd5;
  localparam logic [2:0] REG_VOLTAGE_KP       = 3'd6;
  localparam logic [2:0] REG_VOLTAGE_KI       = 3'd7;

  // clamp a widened sum to plus or minus 1.0
  function automatic logic signed [DataW-1:0] sat_one(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    logic signed [DataW-1:0] res;
    hi = $signed(SumW'(One));
    lo = -hi;
    if (v > hi) begin
      res = $signed(DataW'(One));
    end else if (v < lo) begin
      res = -$signed(DataW'(One));
    end else begin
      res = v[DataW-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/cccv_mulrnd.sv =====
// shared sign-magnitude multiplier with round-to-nearest scaling and registered result
`timescale 1ns / 1ps

module cccv_mulrnd (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [cccv_pkg::ErrW-1:0]  err_i,
  input  logic        [cccv_pkg::RegW-1:0]  gain_i,
  output logic signed [cccv_pkg::RndW-1:0]  prod_o
);
  import cccv_pkg::*;

  logic                    neg;
  logic signed [ErrW-1:0]  err_neg;
  logic        [MagW-1:0]  mag;
  logic        [ProdW:0]   prod_wide;
  logic        [RndW-2:0]  rnd_mag;
  logic signed [RndW-1:0]  rnd_s;
  logic signed [RndW-1:0]  prod_d, prod_q;

  always_comb begin
    neg       = err_i[ErrW-1];
    err_neg   = -err_i;
    mag       = neg ? MagW'(err_neg) : MagW'(err_i);
    // product plus half an lsb, then drop the fraction bits
    prod_wide = ((ProdW+1)'(mag) * (ProdW+1)'(gain_i)) + (ProdW+1)'(One >> 1);
    rnd_mag   = prod_wide[FracBits +: (RndW-1)];
    rnd_s     = $signed({1'b0, rnd_mag});
    prod_d    = neg ? -rnd_s : rnd_s;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/cc_cv_charger_cascaded_pi_core.sv =====
// top level of the cascaded pi constant-current / constant-voltage charge controller
`timescale 1ns / 1ps

// One input transaction is one control tick: current and voltage feedback in Q1.14 plus
// enable set/clear strobes. The block first updates the enable latch and the idle / cc / cv
// mode machine, then, outside idle, runs the voltage pi loop (cv only) and the current pi loop
// on a single shared multiplier with rounding. Each pi loop steps through error, integral
// product, integrator update, proportional product and output sum; the sequencer then waits in
// its output state until the output register is free and returns to idle, where it accepts
// the next tick. The result sits in an output register, and the next tick is accepted while it
// waits to be taken. Configuration writes are expected only between ticks.

module cc_cv_charger_cascaded_pi_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // slave stream, tdata: current_sense, voltage_sense, enable_set, enable_clear, zero pad
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [cccv_pkg::InW-1:0]    s_axis_tdata,
  // master stream, tdata: drive, charge_mode, enabled, zero pad
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [cccv_pkg::OutW-1:0]   m_axis_tdata,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [cccv_pkg::RegW-1:0]   cfg_data_i
);
  import cccv_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MODE  = 3'd1;
  localparam logic [2:0] ST_ERR   = 3'd2;
  localparam logic [2:0] ST_MUL_I = 3'd3;
  localparam logic [2:0] ST_ACC_I = 3'd4;
  localparam logic [2:0] ST_MUL_P = 3'd5;
  localparam logic [2:0] ST_ACC_P = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  // configuration registers
  logic [RegW-1:0] csp_q, vsp_q, cutoff_q, hyst_q, ckp_q, cki_q, vkp_q, vki_q;

  // control state
  logic [2:0]              state_d, state_q;
  logic [1:0]              mode_d, mode_q;
  logic                    latch_d, latch_q;
  logic                    loop_v_d, loop_v_q;     // voltage loop is on the unit
  logic signed [DataW-1:0] cinteg_d, cinteg_q;
  logic signed [DataW-1:0] vinteg_d, vinteg_q;
  logic signed [DataW-1:0] vout_d, vout_q;
  logic signed [DataW-1:0] lastref_d, lastref_q;
  logic                    m_valid_d, m_valid_q;

  // payload
  logic signed [DataW-1:0] is_q, vs_q;
  logic                    set_q, clr_q;
  logic signed [ErrW-1:0]  err_d, err_q;
  logic signed [DataW-1:0] drive_d, drive_q;
  logic [OutW-1:0]         m_data_d, m_data_q;

  // shared unit
  logic                    mul_en;
  logic [RegW-1:0]         mul_gain;
  logic signed [RndW-1:0]  prod;

  // mode machine helpers
  logic                    latch_n;
  logic [1:0]              mode_n;
  logic                    seed_v;
  logic signed [DataW:0]   vs_w, is_w, vsp_w, cut_w, hyst_w, cv_low;

  // loop arithmetic helpers
  logic signed [ErrW-1:0]  ref_e, fb_e;
  logic signed [DataW-1:0] integ_sel;
  logic signed [SumW-1:0]  acc_sum;
  logic signed [DataW-1:0] acc_sat;

  logic in_fire, out_fire;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csp_q    <= '0;
      vsp_q    <= '0;
      cutoff_q <= '0;
      hyst_q   <= '0;
      ckp_q    <= RegW'(One >> 1);        // 0.5
      cki_q    <= RegW'((One + 5) / 10);  // 0.1
      vkp_q    <= RegW'(One >> 1);
      vki_q    <= RegW'((One + 5) / 10);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CURRENT_SETPOINT: csp_q    <= cfg_data_i;
        REG_VOLTAGE_SETPOINT: vsp_q    <= cfg_data_i;
        REG_CUTOFF_CURRENT:   cutoff_q <= cfg_data_i;
        REG_HYSTERESIS_BAND:  hyst_q   <= cfg_data_i;
        REG_CURRENT_KP:       ckp_q    <= cfg_data_i;
        REG_CURRENT_KI:       cki_q    <= cfg_data_i;
        REG_VOLTAGE_KP:       vkp_q    <= cfg_data_i;
        REG_VOLTAGE_KI:       vki_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // mode machine, evaluated once per tick in ST_MODE
  // ---------------------------------------------------------------------------
  always_comb begin
    vs_w   = {vs_q[DataW-1], vs_q};
    is_w   = {is_q[DataW-1], is_q};
    vsp_w  = $signed({2'b00, vsp_q});
    cut_w  = $signed({2'b00, cutoff_q});
    hyst_w = $signed({2'b00, hyst_q});
    cv_low = vsp_w - hyst_w;

    // clear wins over set
    latch_n = clr_q ? 1'b0 : (set_q ? 1'b1 : latch_q);
    mode_n  = mode_q;
    seed_v  = 1'b0;
    unique case (mode_q)
      MODE_IDLE: begin
        if (latch_n) mode_n = MODE_CC;
      end
      MODE_CC: begin
        if (vs_w >= vsp_w) begin
          mode_n = MODE_CV;
          seed_v = 1'b1;
        end
      end
      MODE_CV: begin
        if (vs_w < cv_low) begin
          mode_n = MODE_CC;
        end else if (is_w < cut_w) begin
          // charge complete
          mode_n  = MODE_IDLE;
          latch_n = 1'b0;
        end
      end
      default: mode_n = MODE_IDLE;
    endcase
    if (!latch_n) mode_n = MODE_IDLE;
  end

  // ---------------------------------------------------------------------------
  // loop arithmetic around the shared multiplier
  // ---------------------------------------------------------------------------
  always_comb begin
    if (loop_v_q) begin
      ref_e     = $signed({3'b000, vsp_q});
      fb_e      = {{(ErrW-DataW){vs_q[DataW-1]}}, vs_q};
      integ_sel = vinteg_q;
      mul_gain  = (state_q == ST_MUL_P) ? vkp_q : vki_q;
    end else begin
      ref_e     = {{(ErrW-DataW){lastref_q[DataW-1]}}, lastref_q};
      fb_e      = {{(ErrW-DataW){is_q[DataW-1]}}, is_q};
      integ_sel = cinteg_q;
      mul_gain  = (state_q == ST_MUL_P) ? ckp_q : cki_q;
    end
    acc_sum = {{(SumW-DataW){integ_sel[DataW-1]}}, integ_sel}
            + {{(SumW-RndW){prod[RndW-1]}}, prod};
    acc_sat = sat_one(acc_sum);
  end

  assign mul_en = (state_q == ST_MUL_I) || (state_q == ST_MUL_P);

  cccv_mulrnd u_mulrnd (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .err_i  (err_q),
    .gain_i (mul_gain),
    .prod_o (prod)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    latch_d   = latch_q;
    loop_v_d  = loop_v_q;
    cinteg_d  = cinteg_q;
    vinteg_d  = vinteg_q;
    vout_d    = vout_q;
    lastref_d = lastref_q;
    err_d     = err_q;
    drive_d   = drive_q;
    m_data_d  = m_data_q;
    m_valid_d = m_valid_q && !out_fire;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_MODE;
      end
      ST_MODE: begin
        mode_d  = mode_n;
        latch_d = latch_n;
        if (seed_v) vinteg_d = lastref_q;
        if (mode_n == MODE_IDLE) begin
          cinteg_d = '0;
          drive_d  = '0;
          state_d  = ST_OUT;
        end else if (mode_n == MODE_CV) begin
          loop_v_d = 1'b1;
          state_d  = ST_ERR;
        end else begin
          loop_v_d  = 1'b0;
          lastref_d = $signed({1'b0, csp_q});
          state_d   = ST_ERR;
        end
      end
      ST_ERR: begin
        err_d   = ref_e - fb_e;
        state_d = ST_MUL_I;
      end
      ST_MUL_I: state_d = ST_ACC_I;
      ST_ACC_I: begin
        if (loop_v_q) vinteg_d = acc_sat;
        else          cinteg_d = acc_sat;
        state_d = ST_MUL_P;
      end
      ST_MUL_P: state_d = ST_ACC_P;
      ST_ACC_P: begin
        if (loop_v_q) begin
          // voltage loop output becomes the current reference
          vout_d    = acc_sat;
          lastref_d = acc_sat;
          loop_v_d  = 1'b0;
          state_d   = ST_ERR;
        end else begin
          drive_d = acc_sat;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_d  = OutW'({latch_q, mode_q, drive_q});
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_IDLE;
      latch_q   <= 1'b0;
      loop_v_q  <= 1'b0;
      cinteg_q  <= '0;
      vinteg_q  <= '0;
      vout_q    <= '0;
      lastref_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      latch_q   <= latch_d;
      loop_v_q  <= loop_v_d;
      cinteg_q  <= cinteg_d;
      vinteg_q  <= vinteg_d;
      vout_q    <= vout_d;
      lastref_q <= lastref_d;
      m_valid_q <= m_valid_d;
    end
  end

  // captured tick and datapath payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      is_q  <= $signed(s_axis_tdata[DataW-1:0]);
      vs_q  <= $signed(s_axis_tdata[2*DataW-1:DataW]);
      set_q <= s_axis_tdata[2*DataW];
      clr_q <= s_axis_tdata[2*DataW+1];
    end
    err_q    <= err_d;
    drive_q  <= drive_d;
    m_data_q <= m_data_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTH
  // a mode of 3 never reaches the output
  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[DataW+1:DataW] != 2'd3))
    else $error("illegal charge mode on output");

  // idle mode always comes with zero drive
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[DataW+1:DataW] == MODE_IDLE))
      |-> (m_axis_tdata[DataW-1:0] == '0))
    else $error("nonzero drive in idle");

  // a cleared latch forces idle
  a_latch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[DataW+2])
      |-> (m_axis_tdata[DataW+1:DataW] == MODE_IDLE))
    else $error("active mode with enable latch clear");

  // the current integrator always stays within plus or minus 1.0
  a_cinteg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cinteg_q <= $signed(DataW'(One))) && (cinteg_q >= -$signed(DataW'(One))))
    else $error("current integrator out of range");

  // a tick is never accepted on the cycle after another
  a_one_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("tick accepted while busy");
`endif

endmodule

// ===== test/cccv_tick_checker.sv =====
// tick checker for the cc/cv charge controller: predicts every tick and compares results
`timescale 1ns / 1ps

module cccv_tick_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  // current_sense, voltage_sense, enable_set, enable_clear, zero pad
  input  logic [cccv_pkg::InW-1:0]    s_axis_tdata,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // drive, charge_mode, enabled, zero pad
  input  logic [cccv_pkg::OutW-1:0]   m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [cccv_pkg::RegW-1:0]   cfg_data_i,
  output int                          mismatch_count_o,
  output int                          pending_o,
  output int                          idle_ticks_o,
  output int                          cc_ticks_o,
  output int                          cv_ticks_o
);

  import cccv_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] drive;
    logic [1:0]       mode;
    logic             enabled;
  } tick_result_t;

  tick_result_t expected_q [$];
  tick_result_t seen_res;
  tick_result_t want_res;

  // register copy and controller state
  longint     setting [8];
  logic [1:0] mode_q;
  logic       latch_q;
  longint     cur_integ;
  longint     volt_integ;
  longint     volt_out;
  longint     last_iref;

  int mismatches;
  int idle_ticks;
  int cc_ticks;
  int cv_ticks;

  // error times gain, rounded to nearest with ties away from zero
  function automatic longint gain_term(input longint err, input longint gain);
    longint mag;
    longint rnd;
    mag = (err < 0) ? -err : err;
    rnd = (mag * gain + (longint'(One) >> 1)) >> FracBits;
    return (err < 0) ? -rnd : rnd;
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > longint'(One)) return longint'(One);
    if (v < -longint'(One)) return -longint'(One);
    return v;
  endfunction

  task automatic predict_tick(input logic signed [DataW-1:0] isense,
                              input logic signed [DataW-1:0] vsense,
                              input logic set_b, input logic clr_b,
                              output tick_result_t res);
    longint i_fb;
    longint v_fb;
    longint err;
    longint drv;
    i_fb = isense;
    v_fb = vsense;
    drv  = 0;

    if (clr_b) begin
      latch_q = 1'b0;
    end else if (set_b) begin
      latch_q = 1'b1;
    end

    case (mode_q)
      MODE_IDLE: begin
        if (latch_q) mode_q = MODE_CC;
      end
      MODE_CC: begin
        if (v_fb >= setting[REG_VOLTAGE_SETPOINT]) begin
          mode_q     = MODE_CV;
          volt_integ = last_iref;
        end
      end
      MODE_CV: begin
        if (v_fb < setting[REG_VOLTAGE_SETPOINT] - setting[REG_HYSTERESIS_BAND]) begin
          mode_q = MODE_CC;
        end else if (i_fb < setting[REG_CUTOFF_CURRENT]) begin
          mode_q  = MODE_IDLE;
          latch_q = 1'b0;
        end
      end
      default: begin
        mode_q = MODE_IDLE;
      end
    endcase
    if (!latch_q) mode_q = MODE_IDLE;

    if (mode_q != MODE_IDLE) begin
      if (mode_q == MODE_CV) begin
        err        = setting[REG_VOLTAGE_SETPOINT] - v_fb;
        volt_integ = clamp_unit(volt_integ + gain_term(err, setting[REG_VOLTAGE_KI]));
        volt_out   = clamp_unit(gain_term(err, setting[REG_VOLTAGE_KP]) + volt_integ);
        last_iref  = volt_out;
        cv_ticks++;
      end else begin
        last_iref = setting[REG_CURRENT_SETPOINT];
        cc_ticks++;
      end
      err       = last_iref - i_fb;
      cur_integ = clamp_unit(cur_integ + gain_term(err, setting[REG_CURRENT_KI]));
      drv       = clamp_unit(gain_term(err, setting[REG_CURRENT_KP]) + cur_integ);
    end else begin
      cur_integ = 0;
      idle_ticks++;
    end

    res.drive   = drv[DataW-1:0];
    res.mode    = mode_q;
    res.enabled = latch_q;
  endtask

  task automatic note_mismatch(input bit have_want, input tick_result_t want,
                               input tick_result_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      if (have_want) begin
        $display("%0t mismatch: expected drive %0d mode %0d enabled %0d, got drive %0d mode %0d enabled %0d",
                 $realtime, $signed(want.drive), want.mode, want.enabled,
                 $signed(seen.drive), seen.mode, seen.enabled);
      end else begin
        $display("%0t unexpected result: drive %0d mode %0d enabled %0d",
                 $realtime, $signed(seen.drive), seen.mode, seen.enabled);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setting[REG_CURRENT_SETPOINT] = 0;
      setting[REG_VOLTAGE_SETPOINT] = 0;
      setting[REG_CUTOFF_CURRENT]   = 0;
      setting[REG_HYSTERESIS_BAND]  = 0;
      setting[REG_CURRENT_KP]       = 8192;
      setting[REG_CURRENT_KI]       = 1638;
      setting[REG_VOLTAGE_KP]       = 8192;
      setting[REG_VOLTAGE_KI]       = 1638;
      mode_q     = MODE_IDLE;
      latch_q    = 1'b0;
      cur_integ  = 0;
      volt_integ = 0;
      volt_out   = 0;
      last_iref  = 0;
      expected_q.delete();
      mismatches = 0;
      idle_ticks = 0;
      cc_ticks   = 0;
      cv_ticks   = 0;
      pending_o        <= 0;
      mismatch_count_o <= 0;
      idle_ticks_o     <= 0;
      cc_ticks_o       <= 0;
      cv_ticks_o       <= 0;
    end else begin
      if (cfg_we_i) setting[cfg_idx_i] = cfg_data_i;

      // result side first: no tick can finish on the edge that accepts it
      if (m_axis_tvalid && m_axis_tready) begin
        seen_res.drive   = m_axis_tdata[DataW-1:0];
        seen_res.mode    = m_axis_tdata[DataW+1:DataW];
        seen_res.enabled = m_axis_tdata[DataW+2];
        if (expected_q.size() == 0) begin
          note_mismatch(1'b0, seen_res, seen_res);
        end else begin
          want_res = expected_q.pop_front();
          if (seen_res != want_res) note_mismatch(1'b1, want_res, seen_res);
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        predict_tick($signed(s_axis_tdata[DataW-1:0]), $signed(s_axis_tdata[2*DataW-1:DataW]),
                     s_axis_tdata[2*DataW], s_axis_tdata[2*DataW+1], want_res);
        expected_q.push_back(want_res);
      end

      pending_o        <= expected_q.size();
      mismatch_count_o <= mismatches;
      idle_ticks_o     <= idle_ticks;
      cc_ticks_o       <= cc_ticks;
      cv_ticks_o       <= cv_ticks;
    end
  end

endmodule

// ===== test/cc_cv_charger_cascaded_pi_core_tb.sv =====
// testbench top for the cc/cv charge controller: stimulus, register programming and verdict
`timescale 1ns / 1ps

module cc_cv_charger_cascaded_pi_core_tb;

  import cccv_pkg::*;

  // cycles with no transaction on either stream before the run is abandoned
  localparam int StallLimit = 2000;
  localparam int PhaseTicks = 56;
  localparam int RandPhases = 9;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // current_sense, voltage_sense, enable_set, enable_clear, zero pad
  logic [InW-1:0]    s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // drive, charge_mode, enabled, zero pad
  logic [OutW-1:0]   m_axis_tdata;
  logic              cfg_we_i = 1'b0;
  logic [2:0]        cfg_idx_i = REG_CURRENT_SETPOINT;
  logic [RegW-1:0]   cfg_data_i = '0;

  int mismatch_count;
  int pending;
  int idle_ticks;
  int cc_ticks;
  int cv_ticks;

  // idling odds: one tick (source) or cycle (sink) in this many starts a burst, 0 means none
  int src_odds = 0;
  int sink_odds = 0;
  int sink_hold = 0;
  int quiet_cycles = 0;
  int settings_applied = 0;

  // settings currently programmed, used to aim the random ticks at the thresholds
  int cur_isp;
  int cur_vsp;
  int cur_cut;
  int cur_hyst;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cc_cv_charger_cascaded_pi_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  cccv_tick_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .idle_ticks_o     (idle_ticks),
    .cc_ticks_o       (cc_ticks),
    .cv_ticks_o       (cv_ticks)
  );

  // result sink: ready except during random stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= sink_hold - 1;
    end else if (sink_odds != 0 && $urandom_range(1, sink_odds) == 1) begin
      m_axis_tready <= 1'b0;
      sink_hold     <= $urandom_range(0, 16);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog: counts cycles with no transaction on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= StallLimit);
    $display("watchdog: no transaction for %0d cycles", StallLimit);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic signed [DataW-1:0] clip16(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[DataW-1:0];
  endfunction

  // one control tick; valid stays high between back-to-back ticks
  task automatic send_tick(input int isense, input int vsense, input logic set_b,
                           input logic clr_b);
    int gap;
    gap = 0;
    if (src_odds != 0 && $urandom_range(1, src_odds) == 1) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InW - 2*DataW - 2){1'b0}}, clr_b, set_b, clip16(vsense), clip16(isense)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop sending and wait until every expected result has been taken
  task automatic drain_ticks;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[RegW-1:0];
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input int isp, input int vsp, input int cut, input int hyst,
                                input int ckp, input int cki, input int vkp, input int vki);
    write_reg(REG_CURRENT_SETPOINT, isp);
    write_reg(REG_VOLTAGE_SETPOINT, vsp);
    write_reg(REG_CUTOFF_CURRENT, cut);
    write_reg(REG_HYSTERESIS_BAND, hyst);
    write_reg(REG_CURRENT_KP, ckp);
    write_reg(REG_CURRENT_KI, cki);
    write_reg(REG_VOLTAGE_KP, vkp);
    write_reg(REG_VOLTAGE_KI, vki);
    cfg_we_i <= 1'b0;
    cur_isp  = isp;
    cur_vsp  = vsp;
    cur_cut  = cut;
    cur_hyst = hyst;
    settings_applied++;
  endtask

  function automatic int pick_setpoint;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 32767);
    return $urandom_range(0, 16384);
  endfunction

  function automatic int pick_gain;
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 32767;
      2, 3:    return $urandom_range(0, 16384);
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  task automatic random_settings;
    int isp;
    int vsp;
    int hyst;
    isp  = pick_setpoint();
    vsp  = pick_setpoint();
    // hysteresis is normally a tenth of the voltage setpoint
    hyst = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : vsp / 10;
    apply_settings(isp, vsp, $urandom_range(0, 4096), hyst,
                   pick_gain(), pick_gain(), pick_gain(), pick_gain());
  endtask

  // ticks aimed mostly at the mode thresholds so the cc/cv/idle sequence is walked often
  task automatic random_tick;
    int isense;
    int vsense;
    logic set_b;
    logic clr_b;
    case ($urandom_range(0, 9))
      0, 1:    vsense = $signed(16'($urandom()));
      2, 3, 4: vsense = cur_vsp + $urandom_range(0, 64) - 32;
      5, 6:    vsense = cur_vsp - cur_hyst + $urandom_range(0, 64) - 32;
      7:       vsense = cur_vsp + $urandom_range(0, 4000);
      default: vsense = cur_vsp - cur_hyst - $urandom_range(0, 2000);
    endcase
    case ($urandom_range(0, 9))
      0, 1:    isense = $signed(16'($urandom()));
      2, 3, 4: isense = cur_isp + $urandom_range(0, 1024) - 512;
      5, 6:    isense = cur_cut + $urandom_range(0, 128) - 64;
      default: isense = cur_cut + $urandom_range(0, 8000);
    endcase
    set_b = ($urandom_range(0, 3) == 0);
    clr_b = ($urandom_range(0, 24) == 0);
    send_tick(isense, vsense, set_b, clr_b);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero setpoints, default gains
    send_tick(100, -5, 1'b1, 1'b0);
    send_tick(100, 0, 1'b0, 1'b0);
    send_tick(-32768, 32767, 1'b0, 1'b1);
    drain_ticks();

    // typical settings, walk every mode transition and the threshold edges
    apply_settings(8192, 12000, 1000, 1200, 8192, 1638, 8192, 1638);
    send_tick(-32768, 32767, 1'b0, 1'b0);   // idle, no enable
    send_tick(0, 0, 1'b1, 1'b1);            // clear beats set
    send_tick(-32768, 0, 1'b1, 1'b0);       // into cc, drive saturates high
    send_tick(32767, 0, 1'b0, 1'b0);        // drive goes negative, short of saturation
    send_tick(8192, 11999, 1'b0, 1'b0);     // one below the cv threshold
    send_tick(8192, 12000, 1'b0, 1'b0);     // into cv, integrator seeded
    send_tick(5000, 10800, 1'b0, 1'b0);     // on the hysteresis edge, stays cv
    send_tick(5000, 10799, 1'b0, 1'b0);     // just below it, back to cc
    send_tick(5000, 32767, 1'b0, 1'b0);     // back to cv
    send_tick(999, 12000, 1'b0, 1'b0);      // under cutoff, idle and latch cleared
    send_tick(0, 0, 1'b1, 1'b0);            // restart in cc
    send_tick(0, -32768, 1'b0, 1'b1);       // clear while in cc
    send_tick(0, 0, 1'b1, 1'b0);
    send_tick(1000, 12000, 1'b0, 1'b0);     // cv, exactly at cutoff
    send_tick(0, 12000, 1'b0, 1'b1);        // clear while in cv
    drain_ticks();

    // setpoints and gains at the top of the register range: setpoints above 1.0, seed clamped
    apply_settings(32767, 32767, 0, 0, 32767, 32767, 32767, 32767);
    send_tick(0, 0, 1'b1, 1'b0);
    send_tick(-32768, 0, 1'b0, 1'b0);
    send_tick(0, 32767, 1'b0, 1'b0);
    send_tick(32767, 32766, 1'b0, 1'b0);
    send_tick(32767, 32767, 1'b0, 1'b0);
    send_tick(-1, 32767, 1'b0, 1'b0);
    drain_ticks();

    // zero gains and a cutoff of 1.0
    apply_settings(0, 0, 16384, 0, 0, 0, 0, 0);
    send_tick(-32768, -1, 1'b1, 1'b0);
    send_tick(32767, 0, 1'b0, 1'b0);
    send_tick(16383, 0, 1'b0, 1'b0);
    drain_ticks();

    // random phases, each with fresh settings; idling varies, the last phase has none
    for (int ph = 0; ph < RandPhases; ph++) begin
      random_settings();
      if (ph == RandPhases - 1) begin
        src_odds  = 0;
        sink_odds = 0;
      end else begin
        src_odds  = (ph % 3 == 1) ? 0 : 4;
        sink_odds = (ph % 3 == 2) ? 0 : 5;
      end
      for (int n = 0; n < PhaseTicks; n++) random_tick();
      drain_ticks();
    end

    // allow for a stray late result
    repeat (20) @(posedge clk_i);

    $display("ran %0d ticks under %0d register settings", idle_ticks + cc_ticks + cv_ticks,
             settings_applied);
    $display("ticks by mode: %0d idle, %0d constant current, %0d constant voltage",
             idle_ticks, cc_ticks, cv_ticks);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
